### src/tw_pkg.sv
// Shared types and codes for the timing wheel timer table.
package tw_pkg;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_REFRESH = 2'd1,
    KIND_CANCEL  = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_FULL    = 3'd2,
    ST_EXPIRED = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  localparam logic [6:0] SLOTS_RESET = 7'd60;
  localparam logic [6:0] SLOTS_MAX   = 7'd64;
  localparam int         TMO_W       = 16;

  typedef struct packed {
    logic [31:0] key;
    logic [6:0]  dly;
    logic [6:0]  rem;
    logic        canc;
  } entry_t;

  typedef struct packed {
    logic start;
    logic scan_go;
    logic fin_go;
  } tw_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic can_push;
  } tw_stat_t;

endpackage

### src/tw_ctrl.sv
// Controller state machine for the timer table.
module tw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            cfg_ready,
  output tw_pkg::tw_cmd_t cmd,
  input  tw_pkg::tw_stat_t stat
);

  tw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    cfg_ready   = 1'b0;
    unique case (state)
      tw_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        // A configuration write never lands on the edge that takes an item.
        cfg_ready = !in_valid;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = tw_pkg::S_SCAN;
        end
      end
      tw_pkg::S_SCAN: begin
        cmd.scan_go = 1'b1;
        if (stat.scan_done) begin
          state_next = tw_pkg::S_FINISH;
        end
      end
      tw_pkg::S_FINISH: begin
        if (stat.div_done && stat.can_push) begin
          cmd.fin_go = 1'b1;
          state_next = tw_pkg::S_IDLE;
        end
      end
      default: state_next = tw_pkg::S_IDLE;
    endcase
  end

endmodule

### src/tw_dp.sv
// Datapath: entry memory, scan, delay reduction and result register.
module tw_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  tw_pkg::tw_cmd_t  cmd,
  output tw_pkg::tw_stat_t stat,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_data,
  input  logic [1:0]       kind,
  input  logic [31:0]      timer_id,
  input  logic [15:0]      timeout,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      result_id,
  output logic [2:0]       status,
  output logic             last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  tw_pkg::entry_t mem [TABLE_DEPTH];
  tw_pkg::entry_t rdata;
  logic [TABLE_DEPTH-1:0] vbits;

  logic [6:0]  slots;
  logic [6:0]  ws;
  logic [1:0]  kind_r;
  logic [31:0] id_r;
  logic        tmo_zero;

  logic [CW-1:0] cnt;
  logic          p_valid;
  logic [IW-1:0] p_idx;

  logic          match_found, free_found;
  logic [IW-1:0] match_idx, free_idx;
  tw_pkg::entry_t match_word;
  logic          pend_valid;
  logic [31:0]   pend_id;

  logic [15:0] dq;
  logic [6:0]  dr;
  logic [4:0]  dcnt;
  logic [7:0]  dt;
  logic [7:0]  dt_sub;
  logic [6:0]  delay;

  logic          can_push;
  logic          p_vld_entry, p_expire, p_report, block, adv, rd_en;
  logic          we;
  logic [IW-1:0] waddr;
  tw_pkg::entry_t wdata;
  logic          push;
  logic [31:0]   push_id;
  logic [2:0]    push_st;
  logic          push_last;
  logic          is_tick;

  // Wheel size as used: zero acts as one, above the maximum acts as the maximum.
  always_comb begin
    if (slots == 7'd0) begin
      ws = 7'd1;
    end else if (slots > tw_pkg::SLOTS_MAX) begin
      ws = tw_pkg::SLOTS_MAX;
    end else begin
      ws = slots;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= tw_pkg::SLOTS_RESET;
    end else if (cfg_we) begin
      slots <= cfg_data;
    end
  end

  // Restoring remainder, one dividend bit per cycle.
  assign dt     = {dr, dq[15]};
  assign dt_sub = dt - {1'b0, ws};
  assign delay  = tmo_zero ? ws : dr + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.start) begin
      dcnt <= 5'(tw_pkg::TMO_W);
    end else if (dcnt != 5'd0) begin
      dcnt <= dcnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dq <= timeout - 16'd1;
      dr <= '0;
    end else if (dcnt != 5'd0) begin
      dq <= {dq[14:0], 1'b0};
      dr <= (dt >= {1'b0, ws}) ? dt_sub[6:0] : dt[6:0];
    end
  end

  assign can_push    = !out_valid || !out_stall;
  assign is_tick     = (kind_r == tw_pkg::KIND_TICK);
  assign p_vld_entry = p_valid && vbits[p_idx];
  assign p_expire    = p_vld_entry && (rdata.rem <= 7'd1);
  assign p_report    = p_expire && !rdata.canc;
  assign block       = cmd.scan_go && is_tick && p_report && pend_valid && !can_push;
  assign adv         = cmd.scan_go && !block;
  assign rd_en       = adv && (cnt < DEPTH_C);

  assign stat.scan_done = (cnt == DEPTH_C) && !p_valid;
  assign stat.div_done  = (dcnt == 5'd0);
  assign stat.can_push  = can_push;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[cnt[IW-1:0]];
    end
  end

  // Memory write and result selection.
  always_comb begin
    we        = 1'b0;
    waddr     = p_idx;
    wdata     = rdata;
    push      = 1'b0;
    push_id   = id_r;
    push_st   = tw_pkg::ST_OK;
    push_last = 1'b1;
    if (adv && p_vld_entry && is_tick) begin
      if (p_expire) begin
        if (p_report && pend_valid) begin
          push      = 1'b1;
          push_id   = pend_id;
          push_st   = tw_pkg::ST_EXPIRED;
          push_last = 1'b0;
        end
      end else begin
        we        = 1'b1;
        wdata.rem = rdata.rem - 7'd1;
      end
    end
    if (cmd.fin_go) begin
      push = 1'b1;
      case (kind_r)
        tw_pkg::KIND_TICK: begin
          push_id = pend_valid ? pend_id : 32'd0;
          push_st = pend_valid ? tw_pkg::ST_EXPIRED : tw_pkg::ST_NONE;
        end
        tw_pkg::KIND_ADD: begin
          if (match_found || free_found) begin
            we    = 1'b1;
            waddr = match_found ? match_idx : free_idx;
            wdata = '{key: id_r, dly: delay, rem: delay, canc: 1'b0};
          end else begin
            push_st = tw_pkg::ST_FULL;
          end
        end
        default: begin
          if (match_found) begin
            we    = 1'b1;
            waddr = match_idx;
            wdata = match_word;
            if (kind_r == tw_pkg::KIND_REFRESH) begin
              wdata.rem = match_word.dly;
            end else begin
              wdata.canc = 1'b1;
            end
          end else begin
            push_st = tw_pkg::ST_UNKNOWN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (adv && is_tick && p_expire) begin
      vbits[p_idx] <= 1'b0;
    end else if (cmd.fin_go && kind_r == tw_pkg::KIND_ADD && we) begin
      vbits[waddr] <= 1'b1;
    end
  end

  // Scan control and search results.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      p_valid     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      pend_valid  <= 1'b0;
    end else if (cmd.start) begin
      cnt         <= '0;
      p_valid     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      pend_valid  <= 1'b0;
    end else if (adv) begin
      if (cnt < DEPTH_C) begin
        cnt     <= cnt + 1'b1;
        p_valid <= 1'b1;
      end else begin
        p_valid <= 1'b0;
      end
      if (p_valid && !is_tick) begin
        if (p_vld_entry && rdata.key == id_r && !match_found) begin
          match_found <= 1'b1;
        end
        if (!vbits[p_idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (is_tick && p_report) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r   <= kind;
      id_r     <= timer_id;
      tmo_zero <= (timeout == 16'd0);
    end
    if (rd_en) begin
      p_idx <= cnt[IW-1:0];
    end
    if (adv && p_valid && !is_tick) begin
      if (p_vld_entry && rdata.key == id_r && !match_found) begin
        match_idx  <= p_idx;
        match_word <= rdata;
      end
      if (!vbits[p_idx] && !free_found) begin
        free_idx <= p_idx;
      end
    end
    if (adv && is_tick && p_report) begin
      pend_id <= rdata.key;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result_id <= push_id;
      status    <= push_st;
      last      <= push_last;
    end
  end

endmodule

### src/timing_wheel_timer_table.sv
// Top level of the timing wheel timer table.
// This block keeps up to TABLE_DEPTH timers and handles one input item at a
// time: add, refresh, cancel or tick. Every item is handled by a scan over the
// whole table, one entry per cycle through a memory with a registered read
// port, except that an expiry that meets a result held by out_stall pauses
// the scan; the final result waits for the result register to free up.
// Every item also runs a bit-serial remainder unit beside the scan, which
// reduces the timeout of an add by the wheel size, and the final step waits
// for that unit as well as for the scan. Add, refresh and cancel each give
// one result; a tick gives one result per expired timer that was not
// cancelled, in ascending entry order, or one tick-none result, and last
// marks the final one. The slots register holds the wheel size and is
// written over the cfg port, which accepts a transfer only while no item is
// in progress or offered. No clearing pass is needed after reset.
module timing_wheel_timer_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] timer_id,
  input  logic [15:0] timeout,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_id,
  output logic [2:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  tw_pkg::tw_cmd_t  cmd;
  tw_pkg::tw_stat_t stat;

  // The controller sequences scan and finish; the datapath does the work.
  tw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tw_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .kind      (kind),
    .timer_id  (timer_id),
    .timeout   (timeout),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_id (result_id),
    .status    (status),
    .last      (last)
  );

`ifndef SYNTHESIS
  // A tick-none result is always the single, final result with id zero.
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tw_pkg::ST_NONE |-> last && result_id == 32'd0)
    else $error("tick-none result malformed");

  // Only expiries can be followed by further results of the same item.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != tw_pkg::ST_EXPIRED |-> last)
    else $error("non-expiry result without last");

  // An accepted item keeps the block busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("block not busy after accepting an item");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the timing wheel timer table.
`timescale 1ns / 1ps

module testbench;

  // One result transfer as the block reports it.
  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  st;
    logic        fin;
  } timer_result_t;

  // One row of the directed stimulus table. Where has_typed is set, the
  // result of the row is also compared with the value typed in here.
  typedef struct {
    tw_pkg::kind_t   op;
    logic [31:0]     id;
    logic [15:0]     tmo;
    bit              has_typed;
    tw_pkg::status_t typed_st;
  } plan_row_t;

  localparam int DEPTH       = 16;
  localparam int PLAN_LEN    = 22;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 66;
  localparam int POOL_SIZE   = 22;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = tw_pkg::KIND_TICK;
  logic [31:0] timer_id = '0;
  logic [15:0] timeout = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_id;
  logic [2:0]  status;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  timing_wheel_timer_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .timer_id(timer_id), .timeout(timeout),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_id(result_id), .status(status), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the timer table, kept in step with every accepted transfer.
  logic [6:0]  shadow_slots;
  bit          tmr_used  [DEPTH];
  logic [31:0] tmr_key   [DEPTH];
  logic [6:0]  tmr_delay [DEPTH];
  logic [6:0]  tmr_left  [DEPTH];
  bit          tmr_cancel[DEPTH];

  timer_result_t pending_results[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  timer_result_t last_seen;

  // Append one expected result behind the ones still waiting.
  function automatic void add_expected(timer_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Work out the results of one accepted item and update the shadow table.
  function automatic void predict_item(logic [1:0] op, logic [31:0] id,
                                       logic [15:0] tmo);
    int ws;
    int d;
    int slot;
    int n;
    timer_result_t r;
    ws = (shadow_slots == 0) ? 1 :
         (shadow_slots > tw_pkg::SLOTS_MAX) ? tw_pkg::SLOTS_MAX : shadow_slots;
    slot = -1;
    for (int i = 0; i < DEPTH; i++)
      if (slot < 0 && tmr_used[i] && tmr_key[i] == id) slot = i;
    r.id = id;
    r.fin = 1'b1;
    case (op)
      tw_pkg::KIND_ADD: begin
        d = (tmo == 0) ? ws : ((int'(tmo) - 1) % ws) + 1;
        if (slot < 0)
          for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && !tmr_used[i]) slot = i;
        if (slot < 0) begin
          r.st = tw_pkg::ST_FULL;
        end else begin
          tmr_used[slot]   = 1'b1;
          tmr_key[slot]    = id;
          tmr_delay[slot]  = d[6:0];
          tmr_left[slot]   = d[6:0];
          tmr_cancel[slot] = 1'b0;
          r.st = tw_pkg::ST_OK;
        end
        add_expected(r);
      end
      tw_pkg::KIND_REFRESH, tw_pkg::KIND_CANCEL: begin
        if (slot < 0) begin
          r.st = tw_pkg::ST_UNKNOWN;
        end else begin
          if (op == tw_pkg::KIND_REFRESH) tmr_left[slot] = tmr_delay[slot];
          else tmr_cancel[slot] = 1'b1;
          r.st = tw_pkg::ST_OK;
        end
        add_expected(r);
      end
      default: begin
        // A tick counts every timer down; timers that reach zero leave the
        // table, and only the ones not cancelled are reported.
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (tmr_used[i]) begin
            if (tmr_left[i] <= 1) begin
              tmr_left[i] = '0;
              tmr_used[i] = 1'b0;
              if (!tmr_cancel[i]) begin
                r.id = tmr_key[i];
                r.st = tw_pkg::ST_EXPIRED;
                r.fin = 1'b0;
                add_expected(r);
                n++;
              end
            end else begin
              tmr_left[i] = tmr_left[i] - 7'd1;
            end
          end
        end
        if (n == 0) begin
          r.id = '0;
          r.st = tw_pkg::ST_NONE;
          r.fin = 1'b1;
          add_expected(r);
        end else begin
          pending_results[pending_results.size() - 1].fin = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic note_mismatch(string what, timer_result_t want, timer_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"mismatch (%s) at %0t: expected id=%h status=%0d last=%0d,",
                " got id=%h status=%0d last=%0d"},
               what, $realtime, want.id, want.st, want.fin, got.id, got.st, got.fin);
  endtask

  // The predictor sees each input transfer at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_item(kind, timer_id, timeout);
    if (!rst && cfg_valid && cfg_ready) shadow_slots = cfg_data;
  end

  // Each result transfer is compared with the oldest prediction still waiting.
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{result_id, status, last};
      last_seen = got;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_mismatch("result", want, got);
      end
    end
  end

  // The receiver stalls under a pattern that stall_mode picks at random, anew for
  // each window of stall_count: none, light random, heavy random, or a fixed period.
  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 64 == 63) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_count % 5 < 2);
    endcase
  end

  // Any stretch without a single transfer this long means the block hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sender bursts: burst_left items go back to back, then a random gap.
  int burst_left = 0;

  // Present one item and hold it until the block takes the transfer.
  task automatic send_item(logic [1:0] op, logic [31:0] id, logic [15:0] tmo);
    in_valid <= 1'b1;
    kind     <= op;
    timer_id <= id;
    timeout  <= tmo;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_slots(logic [6:0] value);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  plan_row_t     plan[PLAN_LEN];
  logic [31:0]   id_pool[POOL_SIZE];
  logic [6:0]    phase_slots[PHASES];
  timer_result_t typed;
  int            pick;
  logic [15:0]   tmo_pick;

  initial begin
    shadow_slots = tw_pkg::SLOTS_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      tmr_used[i] = 1'b0;
      tmr_key[i] = '0;
      tmr_delay[i] = '0;
      tmr_left[i] = '0;
      tmr_cancel[i] = 1'b0;
    end

    // Directed part: empty table, extremes of id and timeout, replacement,
    // cancelled expiry, refresh of a cancelled timer and a multi-expiry tick.
    plan = '{
      '{tw_pkg::KIND_TICK,    32'h0,        16'h0,    1'b1, tw_pkg::ST_NONE},
      '{tw_pkg::KIND_REFRESH, 32'h5,        16'h0,    1'b1, tw_pkg::ST_UNKNOWN},
      '{tw_pkg::KIND_CANCEL,  32'h5,        16'hFFFF, 1'b1, tw_pkg::ST_UNKNOWN},
      '{tw_pkg::KIND_ADD,     32'h0,        16'h0,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_ADD,     32'hFFFFFFFF, 16'hFFFF, 1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_ADD,     32'h7,        16'h1,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_ADD,     32'h8,        16'h2,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_CANCEL,  32'h8,        16'h0,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_ADD,     32'h9,        16'h1,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_ADD,     32'h7,        16'h3,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_TICK,    32'h0,        16'h0,    1'b0, tw_pkg::ST_OK},
      '{tw_pkg::KIND_TICK,    32'h0,        16'h0,    1'b0, tw_pkg::ST_OK},
      '{tw_pkg::KIND_REFRESH, 32'hFFFFFFFF, 16'h0,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_CANCEL,  32'h7,        16'h0,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_REFRESH, 32'h7,        16'h0,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_TICK,    32'h0,        16'h0,    1'b0, tw_pkg::ST_OK},
      '{tw_pkg::KIND_TICK,    32'h0,        16'h0,    1'b0, tw_pkg::ST_OK},
      '{tw_pkg::KIND_TICK,    32'h0,        16'h0,    1'b0, tw_pkg::ST_OK},
      '{tw_pkg::KIND_ADD,     32'h12345678, 16'h1,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_ADD,     32'hA5A5A5A5, 16'h3D,   1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_ADD,     32'h5A5A5A5A, 16'h1,    1'b1, tw_pkg::ST_OK},
      '{tw_pkg::KIND_TICK,    32'h0,        16'h0,    1'b0, tw_pkg::ST_OK}
    };
    phase_slots = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd7, 7'd60};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      send_item(plan[i].op, plan[i].id, plan[i].tmo);
      if (plan[i].has_typed) begin
        drain();
        typed = '{plan[i].op == tw_pkg::KIND_TICK ? 32'h0 : plan[i].id,
                  plan[i].typed_st, 1'b1};
        if (last_seen !== typed) note_mismatch("directed row", typed, last_seen);
      end
    end

    // Random part: each phase uses a new wheel size and a small pool of ids,
    // so that the table fills up and refresh and cancel mostly hit.
    for (int p = 0; p < PHASES; p++) begin
      write_slots(phase_slots[p]);
      for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0: tmo_pick = 16'($urandom_range(0, 65535));
          1: tmo_pick = '0;
          default: tmo_pick = 16'($urandom_range(1, 8));
        endcase
        if (pick < 40)
          send_item(tw_pkg::KIND_ADD, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                    tmo_pick);
        else if (pick < 55)
          send_item(tw_pkg::KIND_REFRESH, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                    tmo_pick);
        else if (pick < 68)
          send_item(tw_pkg::KIND_CANCEL, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                    tmo_pick);
        else if (pick < 72)
          send_item(tw_pkg::KIND_REFRESH, $urandom, tmo_pick);
        else
          send_item(tw_pkg::KIND_TICK, $urandom, tmo_pick);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
